// ===== rtl/rv32ex_pkg.sv =====
package rv32ex_pkg;

    localparam int XLEN           = 32;
    localparam int REG_AW         = 5;
    localparam int NUM_REGS       = 32;
    localparam int NUM_LANES      = 4;
    localparam int DMEM_BYTES_DEF = 4096;

    // major opcodes
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_JAL    = 7'h6F;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // ALU funct3
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // load / store funct3
    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LH  = 3'd1;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;
    localparam logic [2:0] F3_SB  = 3'd0;
    localparam logic [2:0] F3_SH  = 3'd1;
    localparam logic [2:0] F3_SW  = 3'd2;

    // branch funct3
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // input beat, opcode in the low bits
    typedef struct packed {
        logic [XLEN-1:0]   immediate;
        logic [REG_AW-1:0] src_reg_b;
        logic [REG_AW-1:0] src_reg_a;
        logic [REG_AW-1:0] dest_reg;
        logic [6:0]        funct7;
        logic [2:0]        funct3;
        logic [6:0]        opcode;
    } instr_t;

    // output beat, next_pc in the low bits
    typedef struct packed {
        logic              unknown_instruction;
        logic              branch_taken;
        logic              reg_written;
        logic [XLEN-1:0]   written_value;
        logic [REG_AW-1:0] written_index;
        logic [XLEN-1:0]   next_pc;
    } result_t;

    localparam int IN_W  = $bits(instr_t);
    localparam int OUT_W = $bits(result_t);

endpackage

// ===== rtl/rv32i_execute_unit.sv =====
// RV32I execute unit: three-stage pipeline (register read, execute/memory access, load align).
// Each instruction passes the register-read, execute and align registers before its result beat.
// Throughput: one instruction per cycle unless the output stalls; a dependent instruction,
// even after a load, issues back to back through forwarding. Register file and data memory
// read ports set the depth. Reset: pipeline empties, PC goes to 0, registers read as zero;
// then the data memory is swept to zero, one 4-byte row per cycle, with input ready held low.
module rv32i_execute_unit #(
    // byte size of the data memory, power of two
    parameter int DMEM_BYTES = rv32ex_pkg::DMEM_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // cfg: start_address; a write loads it into the PC
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rv32ex_pkg::XLEN-1:0]   cfg_data,

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // opcode, funct3, funct7, dest_reg, src_reg_a, src_reg_b, immediate
    input  logic [rv32ex_pkg::IN_W-1:0]   s_axis_tdata,

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // next_pc, written_index, written_value, reg_written, branch_taken,
    // unknown_instruction
    output logic [rv32ex_pkg::OUT_W-1:0]  m_axis_tdata
);

    import rv32ex_pkg::*;

    localparam int DMEM_AW   = $clog2(DMEM_BYTES);
    localparam int DMEM_ROWS = DMEM_BYTES / NUM_LANES;
    localparam int ROW_AW    = DMEM_AW - 2;

    typedef enum logic {ST_CLEAR, ST_RUN} state_t;

    // execute -> load-align stage
    typedef struct packed {
        logic [XLEN-1:0]   npc;
        logic [REG_AW-1:0] rd;       // zero when nothing is written
        logic [XLEN-1:0]   alu_val;
        logic              wr;       // writes a nonzero register
        logic              taken;
        logic              unk;
        logic              load;
        logic [2:0]        f3;
        logic [1:0]        off;      // byte offset within the row
    } exm_t;

    // ------------------------------------------------------------------
    // Control / state
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [ROW_AW-1:0]   clr_cnt_reg, clr_cnt_next;

    logic                adv;        // whole pipeline moves this cycle
    logic                accept;

    logic                s1_valid_reg;
    instr_t              s1_instr_reg;
    logic                s2_valid_reg;
    exm_t                s2_reg, s2_next;
    logic                out_valid_reg;
    result_t             out_reg, out_next;

    logic [XLEN-1:0]     pc_reg;
    logic [NUM_REGS-1:0] rf_valid_reg;   // entry written since reset
    logic                wb_valid_reg;
    logic [REG_AW-1:0]   wb_idx_reg;
    logic [XLEN-1:0]     wb_val_reg;

    // register file
    logic                rf_we;
    logic [XLEN-1:0]     rf_a_rdata, rf_b_rdata;
    logic [XLEN-1:0]     a_fwd, b_fwd;

    // data memory lanes
    logic                dm_we    [NUM_LANES];
    logic [ROW_AW-1:0]   dm_waddr [NUM_LANES];
    logic [7:0]          dm_wdata [NUM_LANES];
    logic                dm_re;
    logic [ROW_AW-1:0]   dm_raddr [NUM_LANES];
    logic [7:0]          dm_rdata [NUM_LANES];

    // execute stage
    logic [XLEN-1:0]     s1_y, s1_addr, pc4;
    logic [ROW_AW-1:0]   row_base;
    logic [ROW_AW-1:0]   lane_row [NUM_LANES];
    logic [1:0]          lane_k   [NUM_LANES];
    logic                lane_en  [NUM_LANES];
    logic                f7ok, alt, cond, wr, unk, is_store;

    // load-align stage
    logic [XLEN-1:0]     ld_word, ld_val, s2_val;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv && (state_reg == ST_RUN);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    // ------------------------------------------------------------------
    // Clearing sweep over the data memory after reset
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        if (state_reg == ST_CLEAR)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ROW_AW'(DMEM_ROWS - 1))
            begin
                state_next = ST_RUN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Register file: two read copies, written together
    // ------------------------------------------------------------------
    assign rf_we = adv && s2_valid_reg && s2_reg.wr;

    rv32ex_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (s2_reg.rd),
        .wdata (s2_val),
        .re    (accept),
        .raddr (s_axis_tdata[26:22]),
        .rdata (rf_a_rdata)
    );

    rv32ex_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (s2_reg.rd),
        .wdata (s2_val),
        .re    (accept),
        .raddr (s_axis_tdata[31:27]),
        .rdata (rf_b_rdata)
    );

    // Operand forwarding: instruction one ahead (still in align stage, load data
    // included), then the write that landed on the read edge, then the array.
    always_comb
    begin
        if (s2_valid_reg && s2_reg.wr && (s2_reg.rd == s1_instr_reg.src_reg_a))
        begin
            a_fwd = s2_val;
        end
        else if (wb_valid_reg && (wb_idx_reg == s1_instr_reg.src_reg_a))
        begin
            a_fwd = wb_val_reg;
        end
        else
        begin
            a_fwd = rf_valid_reg[s1_instr_reg.src_reg_a] ? rf_a_rdata : '0;
        end

        if (s2_valid_reg && s2_reg.wr && (s2_reg.rd == s1_instr_reg.src_reg_b))
        begin
            b_fwd = s2_val;
        end
        else if (wb_valid_reg && (wb_idx_reg == s1_instr_reg.src_reg_b))
        begin
            b_fwd = wb_val_reg;
        end
        else
        begin
            b_fwd = rf_valid_reg[s1_instr_reg.src_reg_b] ? rf_b_rdata : '0;
        end
    end

    // ------------------------------------------------------------------
    // Execute: ALU, branch compare, address generation, store issue
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_y     = (s1_instr_reg.opcode == OPC_OP_IMM) ? s1_instr_reg.immediate : b_fwd;
        s1_addr  = a_fwd + s1_instr_reg.immediate;
        pc4      = pc_reg + 32'd4;
        f7ok     = (s1_instr_reg.funct7 == F7_BASE) || (s1_instr_reg.funct7 == F7_ALT);
        alt      = (s1_instr_reg.funct7 == F7_ALT);
        cond     = 1'b0;
        wr       = 1'b0;
        unk      = 1'b0;
        is_store = 1'b0;

        s2_next         = '0;
        s2_next.npc     = pc4;
        s2_next.f3      = s1_instr_reg.funct3;
        s2_next.off     = s1_addr[1:0];

        unique case (s1_instr_reg.opcode)
            OPC_OP_IMM, OPC_OP:
            begin
                wr = 1'b1;
                unique case (s1_instr_reg.funct3)
                    F3_ADD:
                    begin
                        if ((s1_instr_reg.opcode == OPC_OP) && !f7ok)
                        begin
                            unk = 1'b1;
                        end
                        s2_next.alu_val = ((s1_instr_reg.opcode == OPC_OP) && alt) ?
                                          a_fwd - s1_y : a_fwd + s1_y;
                    end
                    F3_SLL:  s2_next.alu_val = a_fwd << s1_y[4:0];
                    F3_SLT:  s2_next.alu_val = XLEN'($signed(a_fwd) < $signed(s1_y));
                    F3_SLTU: s2_next.alu_val = XLEN'(a_fwd < s1_y);
                    F3_XOR:  s2_next.alu_val = a_fwd ^ s1_y;
                    F3_SR:
                    begin
                        unk = !f7ok;
                        s2_next.alu_val = alt ? XLEN'($signed(a_fwd) >>> s1_y[4:0]) :
                                                a_fwd >> s1_y[4:0];
                    end
                    F3_OR:   s2_next.alu_val = a_fwd | s1_y;
                    F3_AND:  s2_next.alu_val = a_fwd & s1_y;
                endcase
            end
            OPC_LOAD:
            begin
                wr           = 1'b1;
                s2_next.load = 1'b1;
                unk = !((s1_instr_reg.funct3 == F3_LB) || (s1_instr_reg.funct3 == F3_LH) ||
                        (s1_instr_reg.funct3 == F3_LW) || (s1_instr_reg.funct3 == F3_LBU) ||
                        (s1_instr_reg.funct3 == F3_LHU));
            end
            OPC_STORE:
            begin
                is_store = 1'b1;
                unk = !((s1_instr_reg.funct3 == F3_SB) || (s1_instr_reg.funct3 == F3_SH) ||
                        (s1_instr_reg.funct3 == F3_SW));
            end
            OPC_BRANCH:
            begin
                unique case (s1_instr_reg.funct3)
                    F3_BEQ:  cond = (a_fwd == b_fwd);
                    F3_BNE:  cond = (a_fwd != b_fwd);
                    F3_BLT:  cond = ($signed(a_fwd) < $signed(b_fwd));
                    F3_BGE:  cond = !($signed(a_fwd) < $signed(b_fwd));
                    F3_BLTU: cond = (a_fwd < b_fwd);
                    F3_BGEU: cond = (a_fwd >= b_fwd);
                    default: unk  = 1'b1;
                endcase
                if (cond)
                begin
                    s2_next.taken = 1'b1;
                    s2_next.npc   = pc_reg + s1_instr_reg.immediate;
                end
            end
            OPC_LUI:
            begin
                wr              = 1'b1;
                s2_next.alu_val = s1_instr_reg.immediate;
            end
            OPC_AUIPC:
            begin
                wr              = 1'b1;
                s2_next.alu_val = pc_reg + s1_instr_reg.immediate;
            end
            OPC_JAL:
            begin
                wr              = 1'b1;
                s2_next.alu_val = pc4;
                s2_next.taken   = 1'b1;
                s2_next.npc     = pc_reg + s1_instr_reg.immediate;
            end
            OPC_JALR:
            begin
                wr              = 1'b1;
                s2_next.alu_val = pc4;
                s2_next.taken   = 1'b1;
                s2_next.npc     = {s1_addr[XLEN-1:1], 1'b0};
            end
            default: unk = 1'b1;
        endcase

        // unknown encodings leave all state alone and fall through
        if (unk)
        begin
            wr            = 1'b0;
            is_store      = 1'b0;
            s2_next.taken = 1'b0;
            s2_next.npc   = pc4;
        end
        s2_next.unk  = unk;
        s2_next.wr   = wr && (s1_instr_reg.dest_reg != '0);
        s2_next.rd   = s2_next.wr ? s1_instr_reg.dest_reg : '0;
        s2_next.load = s2_next.load && s2_next.wr;
    end

    // Byte lanes: byte k of the access sits in lane (off + k) mod 4; lanes below
    // the offset take the next row, which wraps at the end of memory.
    assign row_base = s1_addr[DMEM_AW-1:2];

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            lane_k[l]   = 2'(l) - s1_addr[1:0];
            lane_row[l] = row_base + {{(ROW_AW-1){1'b0}}, (2'(l) < s1_addr[1:0])};
            unique case (s1_instr_reg.funct3)
                F3_SB:   lane_en[l] = (lane_k[l] == 2'd0);
                F3_SH:   lane_en[l] = (lane_k[l] <= 2'd1);
                default: lane_en[l] = 1'b1;
            endcase

            if (state_reg == ST_CLEAR)
            begin
                dm_we[l]    = 1'b1;
                dm_waddr[l] = clr_cnt_reg;
                dm_wdata[l] = '0;
            end
            else
            begin
                dm_we[l]    = adv && s1_valid_reg && is_store && lane_en[l];
                dm_waddr[l] = lane_row[l];
                dm_wdata[l] = b_fwd[8*lane_k[l] +: 8];
            end
            dm_raddr[l] = lane_row[l];
        end
    end

    assign dm_re = adv && s1_valid_reg && s2_next.load;

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        rv32ex_ram #(.WIDTH(8), .DEPTH(DMEM_ROWS)) u_dmem (
            .clk   (clk),
            .we    (dm_we[g]),
            .waddr (dm_waddr[g]),
            .wdata (dm_wdata[g]),
            .re    (dm_re),
            .raddr (dm_raddr[g]),
            .rdata (dm_rdata[g])
        );
    end

    // ------------------------------------------------------------------
    // Load align and result
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            ld_word[8*k +: 8] = dm_rdata[2'(k) + s2_reg.off];
        end

        unique case (s2_reg.f3)
            F3_LB:   ld_val = {{24{ld_word[7]}}, ld_word[7:0]};
            F3_LH:   ld_val = {{16{ld_word[15]}}, ld_word[15:0]};
            F3_LBU:  ld_val = {24'd0, ld_word[7:0]};
            F3_LHU:  ld_val = {16'd0, ld_word[15:0]};
            default: ld_val = ld_word;
        endcase

        if (!s2_reg.wr)
        begin
            s2_val = '0;
        end
        else
        begin
            s2_val = s2_reg.load ? ld_val : s2_reg.alu_val;
        end

        out_next.unknown_instruction = s2_reg.unk;
        out_next.branch_taken        = s2_reg.taken;
        out_next.reg_written         = s2_reg.wr;
        out_next.written_value       = s2_val;
        out_next.written_index       = s2_reg.rd;
        out_next.next_pc             = s2_reg.npc;
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            rf_valid_reg  <= '0;
            wb_valid_reg  <= 1'b0;
            wb_idx_reg    <= '0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg  <= accept;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
                if (rf_we)
                begin
                    rf_valid_reg[s2_reg.rd] <= 1'b1;
                    wb_valid_reg            <= 1'b1;
                    wb_idx_reg              <= s2_reg.rd;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                pc_reg <= cfg_data;
            end
            else if (adv && s1_valid_reg)
            begin
                pc_reg <= s2_next.npc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_instr_reg <= instr_t'(s_axis_tdata);
        end
        if (adv)
        begin
            s2_reg  <= s2_next;
            out_reg <= out_next;
        end
        if (rf_we)
        begin
            wb_val_reg <= s2_val;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_axis_tready)
        else $error("input accepted during data memory clear");

    a_unknown_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.unknown_instruction) |->
        (!out_reg.reg_written && !out_reg.branch_taken))
        else $error("unknown instruction reported a side effect");

    a_write_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.reg_written) |-> (out_reg.written_index != '0))
        else $error("register write reported to x0");

    a_x0_never_written: assert property (@(posedge clk) disable iff (!rst_n)
        !rf_valid_reg[0])
        else $error("x0 written in register file");

    a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s1_valid_reg) |=> s2_valid_reg)
        else $error("instruction lost between execute and align");
`endif

endmodule

// ===== rtl/rv32ex_ram.sv =====
module rv32ex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
